### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/rvx_pkg.sv
package rvx_pkg;

    localparam int DATA_BYTES = 65536;
    localparam int ADDR_W     = $clog2(DATA_BYTES);
    localparam int IN_W       = 88;
    localparam int OUT_W      = 88;

    localparam logic [31:0] RESET_BASE    = 32'h1000_0000;
    localparam logic [31:0] RESET_CONSOLE = 32'h1000_0000;

    // Configuration register indexes
    localparam logic CFG_DATA_BASE = 1'b0;
    localparam logic CFG_CONSOLE   = 1'b1;

    // Opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_BASE   = 7'h00;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    typedef enum logic [3:0] {
        CLS_PRELOAD,
        CLS_ALU,
        CLS_LOAD,
        CLS_STORE,
        CLS_BRANCH,
        CLS_LUI,
        CLS_AUIPC,
        CLS_JAL,
        CLS_JALR,
        CLS_ILLEGAL
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] instr;
        logic [31:0] console_in;
        logic [15:0] load_addr;
        logic [7:0]  load_byte;
    } item_t;

    // Back end to front end control
    typedef struct packed {
        logic pop;
        logic clear_done;
    } back_ctl_t;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_LOAD,
        BS_STORE,
        BS_FIN
    } bstate_t;

    // Sort an incoming word into its instruction class
    function automatic cls_t classify(input logic kind, input logic [31:0] ins);
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        logic       f7_ok;
        cls_t       c;
        op    = ins[6:0];
        f3    = ins[14:12];
        f7    = ins[31:25];
        f7_ok = (f7 == F7_BASE) || (f7 == F7_ALT);
        c     = CLS_ILLEGAL;
        if (kind)
        begin
            c = CLS_PRELOAD;
        end
        else
        begin
            case (op)
                OP_REG:    c = ((f3 == 3'd0 || f3 == 3'd5) && !f7_ok) ? CLS_ILLEGAL : CLS_ALU;
                OP_IMM:    c = (f3 == 3'd5 && !f7_ok) ? CLS_ILLEGAL : CLS_ALU;
                OP_LOAD:   c = (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ? CLS_ILLEGAL
                                                                           : CLS_LOAD;
                OP_STORE:  c = (f3 > 3'd2) ? CLS_ILLEGAL : CLS_STORE;
                OP_BRANCH: c = (f3 == 3'd2 || f3 == 3'd3) ? CLS_ILLEGAL : CLS_BRANCH;
                OP_LUI:    c = CLS_LUI;
                OP_AUIPC:  c = CLS_AUIPC;
                OP_JAL:    c = CLS_JAL;
                OP_JALR:   c = CLS_JALR;
                default:   c = CLS_ILLEGAL;
            endcase
        end
        return c;
    endfunction

endpackage

### rtl/rv32i_instruction_executor.sv
// RV32I executor: one instruction word (or one data memory preload byte) per
// input word, one result word per input. After reset the data memory is
// cleared one byte a cycle (DATA_BYTES = 65536 bytes) and no input is taken
// until that pass ends; configuration writes are taken at any time. Inputs are
// classified and queued (two deep) by the front end; the back end runs each
// item through its sequencer (register file read, execute, write back, which
// waits for a free output register); loads and stores add a memory step for
// each byte moved through the byte-wide data memory port (1, 2 or 4).
// A result waits in the output register while the next item is already taken.
module rv32i_instruction_executor
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // instr[31:0], console_in[63:32], load_addr[79:64], load_byte[87:80]
    input  logic [rvx_pkg::IN_W-1:0]  s_tdata,
    // kind
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[1:0], next_pc[33:2], reg_written[34], reg_index[39:35],
    // reg_value[71:40], console_valid[72], console_byte[80:73],
    // console_read[81], zero[87:82]
    output logic [rvx_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [31:0]               cfg_data
);

    rvx_pkg::back_ctl_t ctl;
    rvx_pkg::item_t     q_item;
    logic               q_valid;

    rvx_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctl      (ctl),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    rvx_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .ctl       (ctl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/rvx_front.sv
module rvx_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rvx_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tuser,
    input  rvx_pkg::back_ctl_t        ctl,
    output logic                      q_valid,
    output rvx_pkg::item_t            q_item
);

    rvx_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    rvx_pkg::item_t in_item;

    // Classify the incoming word
    always_comb
    begin
        in_item.cls        = rvx_pkg::classify(s_tuser, s_tdata[31:0]);
        in_item.instr      = s_tdata[31:0];
        in_item.console_in = s_tdata[63:32];
        in_item.load_addr  = s_tdata[79:64];
        in_item.load_byte  = s_tdata[87:80];
    end

    assign s_tready = ctl.clear_done && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/rvx_back.sv
module rvx_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      q_valid,
    input  rvx_pkg::item_t            q_item,
    output rvx_pkg::back_ctl_t        ctl,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [rvx_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = rvx_pkg::ADDR_W;

    rvx_pkg::bstate_t state_reg, state_next;
    rvx_pkg::item_t   cur_reg, cur_next;

    logic [31:0]   pc_reg, pc_next;
    logic [31:0]   base_reg, cons_reg;
    logic [31:0]   a_reg, b_reg;
    logic [31:0]   rf [32];
    logic [31:0]   rf_vld_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [1:0]    n1_reg, n1_next;
    logic [31:0]   off_reg, off_next;

    logic [1:0]    st_reg, st_next;
    logic [31:0]   npc_reg, npc_next;
    logic          wr_reg, wr_next;
    logic [31:0]   wval_reg, wval_next;
    logic          cv_reg, cv_next;
    logic [7:0]    cbyte_reg, cbyte_next;
    logic          cr_reg, cr_next;

    logic                      out_valid_reg;
    logic [rvx_pkg::OUT_W-1:0] out_data_reg;

    logic [7:0]    mem [rvx_pkg::DATA_BYTES];
    logic [7:0]    mem_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic          fin_fire;
    logic [4:0]    rd;
    logic [2:0]    f3;
    logic [31:0]   ins, imm_i, imm_s, imm_b, imm_j, y, off_ld, off_st, asm_val;
    logic          alt, is_reg;
    logic [4:0]    sh;

    // Access of n bytes fits when off <= DATA_BYTES - n
    function automatic logic in_rng(input logic [31:0] off, input logic [2:0] n);
        return {1'b0, off} <= (33'(rvx_pkg::DATA_BYTES) - 33'(n));
    endfunction

    // Instruction fields
    always_comb
    begin
        ins    = cur_reg.instr;
        rd     = ins[11:7];
        f3     = ins[14:12];
        alt    = (ins[31:25] == rvx_pkg::F7_ALT);
        is_reg = ins[5];
        imm_i  = {{20{ins[31]}}, ins[31:20]};
        imm_s  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        y      = is_reg ? b_reg : imm_i;
        sh     = y[4:0];
        off_ld = a_reg + imm_i - base_reg;
        off_st = a_reg + imm_s - base_reg;
        asm_val = wval_reg | ({24'b0, mem_q} << {cnt_reg, 3'b000});
    end

    assign fin_fire       = (state_reg == rvx_pkg::BS_FIN) && (!out_valid_reg || m_tready);
    assign ctl.clear_done = (state_reg != rvx_pkg::BS_CLEAR);
    assign ctl.pop        = (state_reg == rvx_pkg::BS_IDLE) && q_valid;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rvx_pkg::BS_CLEAR:
                if (&clr_reg) state_next = rvx_pkg::BS_IDLE;
            rvx_pkg::BS_IDLE:
                if (q_valid) state_next = rvx_pkg::BS_EXEC;
            rvx_pkg::BS_EXEC:
            begin
                state_next = rvx_pkg::BS_FIN;
                if (cur_reg.cls == rvx_pkg::CLS_LOAD && !(f3 == 3'd2 && off_ld == cons_reg)
                    && in_rng(off_ld, (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4))
                    state_next = rvx_pkg::BS_LOAD;
                if (cur_reg.cls == rvx_pkg::CLS_STORE && !(f3 != 3'd1 && off_st == cons_reg)
                    && in_rng(off_st, (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4))
                    state_next = rvx_pkg::BS_STORE;
            end
            rvx_pkg::BS_LOAD:
                if (cnt_reg == n1_reg) state_next = rvx_pkg::BS_FIN;
            rvx_pkg::BS_STORE:
                if (cnt_reg == n1_reg) state_next = rvx_pkg::BS_FIN;
            rvx_pkg::BS_FIN:
                if (fin_fire) state_next = rvx_pkg::BS_IDLE;
            default:
                state_next = rvx_pkg::BS_IDLE;
        endcase
    end

    // Datapath and memory controls per state
    always_comb
    begin
        cur_next   = cur_reg;
        pc_next    = pc_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        n1_next    = n1_reg;
        off_next   = off_reg;
        st_next    = st_reg;
        npc_next   = npc_reg;
        wr_next    = wr_reg;
        wval_next  = wval_reg;
        cv_next    = cv_reg;
        cbyte_next = cbyte_reg;
        cr_next    = cr_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = 8'h00;
        mem_re     = 1'b0;
        mem_raddr  = off_reg[AW-1:0];
        case (state_reg)
            rvx_pkg::BS_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            rvx_pkg::BS_IDLE:
                if (q_valid) cur_next = q_item;
            rvx_pkg::BS_EXEC:
            begin
                st_next    = rvx_pkg::ST_OK;
                npc_next   = pc_reg + 32'd4;
                wr_next    = 1'b0;
                wval_next  = 32'd0;
                cv_next    = 1'b0;
                cbyte_next = 8'h00;
                cr_next    = 1'b0;
                cnt_next   = 2'd0;
                case (cur_reg.cls)
                    rvx_pkg::CLS_PRELOAD:
                    begin
                        npc_next = pc_reg;
                        if (32'(cur_reg.load_addr) < 32'(rvx_pkg::DATA_BYTES))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(32'(cur_reg.load_addr));
                            mem_wdata = cur_reg.load_byte;
                        end
                        else
                        begin
                            st_next = rvx_pkg::ST_RANGE;
                        end
                    end
                    rvx_pkg::CLS_ALU:
                    begin
                        wr_next = 1'b1;
                        case (f3)
                            3'd0: wval_next = (is_reg && alt) ? a_reg - y : a_reg + y;
                            3'd1: wval_next = a_reg << sh;
                            3'd2: wval_next = {31'b0, $signed(a_reg) < $signed(y)};
                            3'd3: wval_next = {31'b0, a_reg < y};
                            3'd4: wval_next = a_reg ^ y;
                            3'd5: wval_next = alt ? 32'($signed(a_reg) >>> sh) : a_reg >> sh;
                            3'd6: wval_next = a_reg | y;
                            default: wval_next = a_reg & y;
                        endcase
                    end
                    rvx_pkg::CLS_LOAD:
                    begin
                        off_next  = off_ld;
                        mem_re    = 1'b1;
                        mem_raddr = off_ld[AW-1:0];
                        n1_next   = (f3[1:0] == 2'd0) ? 2'd0 : (f3[1:0] == 2'd1) ? 2'd1 : 2'd3;
                        if (f3 == 3'd2 && off_ld == cons_reg)
                        begin
                            wr_next   = 1'b1;
                            cr_next   = 1'b1;
                            wval_next = cur_reg.console_in;
                        end
                        else if (!in_rng(off_ld, 3'(n1_next) + 3'd1))
                        begin
                            st_next = rvx_pkg::ST_RANGE;
                        end
                    end
                    rvx_pkg::CLS_STORE:
                    begin
                        off_next = off_st;
                        n1_next  = (f3 == 3'd0) ? 2'd0 : (f3 == 3'd1) ? 2'd1 : 2'd3;
                        if (f3 != 3'd1 && off_st == cons_reg)
                        begin
                            if (f3 == 3'd0 || b_reg < 32'h7F)
                            begin
                                cv_next    = 1'b1;
                                cbyte_next = b_reg[7:0];
                            end
                        end
                        else if (!in_rng(off_st, 3'(n1_next) + 3'd1))
                        begin
                            st_next = rvx_pkg::ST_RANGE;
                        end
                    end
                    rvx_pkg::CLS_BRANCH:
                    begin
                        case (f3)
                            3'd0: if (a_reg == b_reg) npc_next = pc_reg + imm_b;
                            3'd1: if (a_reg != b_reg) npc_next = pc_reg + imm_b;
                            3'd4: if ($signed(a_reg) < $signed(b_reg)) npc_next = pc_reg + imm_b;
                            3'd5: if ($signed(a_reg) >= $signed(b_reg)) npc_next = pc_reg + imm_b;
                            3'd6: if (a_reg < b_reg) npc_next = pc_reg + imm_b;
                            default: if (a_reg >= b_reg) npc_next = pc_reg + imm_b;
                        endcase
                    end
                    rvx_pkg::CLS_LUI:
                    begin
                        wr_next   = 1'b1;
                        wval_next = {ins[31:12], 12'b0};
                    end
                    rvx_pkg::CLS_AUIPC:
                    begin
                        wr_next   = 1'b1;
                        wval_next = pc_reg + {ins[31:12], 12'b0};
                    end
                    rvx_pkg::CLS_JAL:
                    begin
                        wr_next   = 1'b1;
                        wval_next = pc_reg + 32'd4;
                        npc_next  = pc_reg + imm_j;
                    end
                    rvx_pkg::CLS_JALR:
                    begin
                        wr_next   = 1'b1;
                        wval_next = pc_reg + 32'd4;
                        npc_next  = (a_reg + imm_i) & ~32'd1;
                    end
                    default:
                        st_next = rvx_pkg::ST_ILLEGAL;
                endcase
            end
            rvx_pkg::BS_LOAD:
            begin
                // mem_q holds byte cnt of the access
                wval_next = asm_val;
                if (cnt_reg == n1_reg)
                begin
                    wr_next = 1'b1;
                    case (f3)
                        3'd0:    wval_next = {{24{asm_val[7]}}, asm_val[7:0]};
                        3'd1:    wval_next = {{16{asm_val[15]}}, asm_val[15:0]};
                        default: wval_next = asm_val;
                    endcase
                end
                else
                begin
                    cnt_next  = cnt_reg + 2'd1;
                    mem_re    = 1'b1;
                    mem_raddr = off_reg[AW-1:0] + AW'(cnt_next);
                end
            end
            rvx_pkg::BS_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = off_reg[AW-1:0] + AW'(cnt_reg);
                mem_wdata = 8'(b_reg >> {cnt_reg, 3'b000});
                cnt_next  = cnt_reg + 2'd1;
            end
            rvx_pkg::BS_FIN:
            begin
                if (fin_fire) pc_next = npc_reg;
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rvx_pkg::BS_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 32'd0;
            base_reg      <= rvx_pkg::RESET_BASE;
            cons_reg      <= rvx_pkg::RESET_CONSOLE;
            rf_vld_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            if (cfg_we && cfg_index == rvx_pkg::CFG_DATA_BASE) base_reg <= cfg_data;
            if (cfg_we && cfg_index == rvx_pkg::CFG_CONSOLE)   cons_reg <= cfg_data;
            if (fin_fire && wr_reg && rd != 5'd0) rf_vld_reg[rd] <= 1'b1;
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        n1_reg    <= n1_next;
        off_reg   <= off_next;
        st_reg    <= st_next;
        npc_reg   <= npc_next;
        wr_reg    <= wr_next;
        wval_reg  <= wval_next;
        cv_reg    <= cv_next;
        cbyte_reg <= cbyte_next;
        cr_reg    <= cr_next;
        if (state_reg == rvx_pkg::BS_IDLE)
        begin
            a_reg <= rf_vld_reg[q_item.instr[19:15]] ? rf[q_item.instr[19:15]] : 32'd0;
            b_reg <= rf_vld_reg[q_item.instr[24:20]] ? rf[q_item.instr[24:20]] : 32'd0;
        end
        if (fin_fire && wr_reg && rd != 5'd0)
            rf[rd] <= wval_reg;
        if (fin_fire)
        begin
            if (wr_reg && rd != 5'd0)
                out_data_reg <= {6'b0, cr_reg, cbyte_reg, cv_reg, wval_reg, rd, 1'b1,
                                 npc_reg, st_reg};
            else
                out_data_reg <= {6'b0, cr_reg, cbyte_reg, cv_reg, 32'd0, 5'd0, 1'b0,
                                 npc_reg, st_reg};
        end
    end

    // Data memory
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_q <= mem[mem_raddr];
    end

endmodule

### rtl/rvx_checker.sv
`include "assert_macros.svh"

module rvx_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rvx_pkg::OUT_W-1:0] m_tdata
);

    // Result held while stalled
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Padding stays zero
    `ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[87:82] == 6'd0)
    // No register write means zero index and value
    `ASSERT_NOW(a_no_wr_zero, m_tvalid && !m_tdata[34], m_tdata[71:35] == 37'd0)
    // A console write never writes a register
    `ASSERT_NOW(a_cons_no_wr, m_tvalid && m_tdata[72], !m_tdata[34])
    // Status code three is never produced
    `ASSERT_NOW(a_status_ok, m_tvalid, m_tdata[1:0] != 2'd3)

endmodule

bind rv32i_instruction_executor rvx_checker u_rvx_checker (.*);
